/* src/spot_pkg.sv */
// shared constants for the shape pair overlap test
`default_nettype none

package spot_pkg;

  // default coordinate width, signed fixed point
  localparam int COORD_WIDTH_DEF = 32;

  // shape kind codes
  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_BOX    = 1'b1;

endpackage : spot_pkg

`default_nettype wire

/* src/shape_pair_overlap_test.sv */
// narrow-phase overlap test for a sphere or box pair, one shared multiplier
//
// Shapes arrive one beat at a time on start_i while busy_o is low. A beat with
// second_i low stores its shape and leaves busy_o low, so the next beat may
// follow at once. A beat with second_i high tests its shape against the stored
// one and gives one result beat on done_o. When a sphere is involved it forms
// four squares, each a distance set-up state and then three partial products
// of a shared half-width multiplier, followed by a drain and a compare state;
// box against box takes one axis per cycle, then the compare. done_o is high
// in the first cycle with busy_o low again, and a new beat may be taken in
// that same cycle. The result beat is shown for one cycle only and must be
// taken then. The stored shape stays in place for later second beats. A
// second beat before any first beat since reset gives an unspecified hit.
`default_nettype none

module shape_pair_overlap_test #(
  parameter int COORD_WIDTH = spot_pkg::COORD_WIDTH_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start_i,
  output logic                           busy_o,
  input  wire                            second_i,
  input  wire                            kind_i,
  input  wire  signed [COORD_WIDTH-1:0]  centre_x_i,
  input  wire  signed [COORD_WIDTH-1:0]  centre_y_i,
  input  wire  signed [COORD_WIDTH-1:0]  centre_z_i,
  input  wire         [COORD_WIDTH-2:0]  extent_x_i,
  input  wire         [COORD_WIDTH-2:0]  extent_y_i,
  input  wire         [COORD_WIDTH-2:0]  extent_z_i,
  output logic                           done_o,
  output logic                           hit_o,
  output logic        [1:0]              pair_kind_o
);

  // derived widths
  localparam int EW = COORD_WIDTH - 1;       // extent width
  localparam int XW = COORD_WIDTH + 2;       // signed working width
  localparam int H  = (COORD_WIDTH + 1) / 2; // multiplier operand width
  localparam int D  = 2 * H;                 // distance and product width
  localparam int AW = 2 * D + 2;             // sum of squares width

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;

  // axis codes, the last one is the radius term
  localparam logic [1:0] AX_X   = 2'd0;
  localparam logic [1:0] AX_Z   = 2'd2;
  localparam logic [1:0] AX_RAD = 2'd3;

  // partial product steps
  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HH = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [1:0] step_q, step_d;
  logic       padd_q, padd_d;
  logic       done_q, done_d;
  logic       held_kind_q;

  logic signed [COORD_WIDTH-1:0] held_c_q [3];
  logic        [EW-1:0]          held_e_q [3];
  logic signed [COORD_WIDTH-1:0] cur_c_q  [3];
  logic        [EW-1:0]          cur_e_q  [3];
  logic                          cur_kind_q;

  logic [D-1:0]  d_q;
  logic [D-1:0]  prod_q;
  logic [1:0]    psh_q;
  logic          ptgt_q;
  logic [AW-1:0] acc_q;
  logic [AW-1:0] rsq_q;
  logic          boxhit_q;
  logic          hit_q;
  logic [1:0]    pk_q;

  logic accept_first, accept_second, box_pair, sphere_pair;

  assign accept_first  = start_i && !busy_o && !second_i;
  assign accept_second = start_i && !busy_o && second_i;
  assign box_pair      = (held_kind_q == spot_pkg::KIND_BOX) &&
                         (cur_kind_q == spot_pkg::KIND_BOX);
  assign sphere_pair   = (held_kind_q == spot_pkg::KIND_SPHERE) &&
                         (cur_kind_q == spot_pkg::KIND_SPHERE);

  // per-axis distance unit
  logic [1:0]              axis_idx;
  logic signed [XW-1:0]    hc_x, cc_x, he_x, ce_x;
  logic signed [XW-1:0]    diff, s_x, bc_x, be_x, lo_x, hi_x, dlo, dhi;
  logic [COORD_WIDTH-1:0]  adiff, esum, clamp_d, radius;
  logic [D-1:0]            d_sel;

  assign axis_idx = (axis_q == AX_RAD) ? AX_X : axis_q;
  assign hc_x     = XW'(held_c_q[axis_idx]);
  assign cc_x     = XW'(cur_c_q[axis_idx]);
  assign he_x     = signed'({3'b000, held_e_q[axis_idx]});
  assign ce_x     = signed'({3'b000, cur_e_q[axis_idx]});

  assign diff  = hc_x - cc_x;
  assign adiff = diff[XW-1] ? COORD_WIDTH'(-diff) : COORD_WIDTH'(diff);
  assign esum  = COORD_WIDTH'({1'b0, held_e_q[axis_idx]}) +
                 COORD_WIDTH'({1'b0, cur_e_q[axis_idx]});

  // sphere centre against the box slab on this axis
  always_comb begin
    if (held_kind_q == spot_pkg::KIND_SPHERE) begin
      s_x  = hc_x;
      bc_x = cc_x;
      be_x = ce_x;
    end else begin
      s_x  = cc_x;
      bc_x = hc_x;
      be_x = he_x;
    end
  end

  assign lo_x = bc_x - be_x;
  assign hi_x = bc_x + be_x;
  assign dlo  = lo_x - s_x;
  assign dhi  = s_x - hi_x;

  always_comb begin
    if (s_x < lo_x) begin
      clamp_d = COORD_WIDTH'(dlo);
    end else if (s_x > hi_x) begin
      clamp_d = COORD_WIDTH'(dhi);
    end else begin
      clamp_d = '0;
    end
  end

  // radius term: sum of radii, or the one sphere radius
  always_comb begin
    if (sphere_pair) begin
      radius = esum;
    end else if (held_kind_q == spot_pkg::KIND_SPHERE) begin
      radius = COORD_WIDTH'(held_e_q[AX_X]);
    end else begin
      radius = COORD_WIDTH'(cur_e_q[AX_X]);
    end
  end

  always_comb begin
    if (axis_q == AX_RAD) begin
      d_sel = D'(radius);
    end else if (sphere_pair) begin
      d_sel = D'(adiff);
    end else begin
      d_sel = D'(clamp_d);
    end
  end

  // shared half-width multiplier
  logic [H-1:0] d_lo, d_hi, mul_a, mul_b;
  logic [D-1:0] mul_p;

  assign d_lo  = d_q[H-1:0];
  assign d_hi  = d_q[D-1:H];
  assign mul_a = (step_q == STEP_HH) ? d_hi : d_lo;
  assign mul_b = (step_q == STEP_LL) ? d_lo : d_hi;
  assign mul_p = D'(mul_a) * D'(mul_b);

  // place the registered partial product
  logic [AW-1:0] prod_sh;

  always_comb begin
    case (psh_q)
      STEP_LL: prod_sh = AW'(prod_q);
      STEP_LH: prod_sh = AW'(prod_q) << (H + 1);
      STEP_HH: prod_sh = AW'(prod_q) << (2 * H);
      default: prod_sh = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    step_d  = step_q;
    padd_d  = 1'b0;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept_second) begin
          state_d = ST_PREP;
          axis_d  = AX_X;
        end
      end
      ST_PREP: begin
        if (box_pair) begin
          if (axis_q == AX_Z) begin
            state_d = ST_CMP;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end else begin
          state_d = ST_MUL;
          step_d  = STEP_LL;
        end
      end
      ST_MUL: begin
        padd_d = 1'b1;
        if (step_q == STEP_HH) begin
          if (axis_q == AX_RAD) begin
            state_d = ST_DRAIN;
          end else begin
            axis_d  = axis_q + 2'd1;
            state_d = ST_PREP;
          end
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= AX_X;
      step_q      <= STEP_LL;
      padd_q      <= 1'b0;
      done_q      <= 1'b0;
      held_kind_q <= spot_pkg::KIND_SPHERE;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      step_q  <= step_d;
      padd_q  <= padd_d;
      done_q  <= done_d;
      if (accept_first) begin
        held_kind_q <= kind_i;
      end
    end
  end

  // held shape and working item
  always_ff @(posedge clk_i) begin
    if (accept_first) begin
      held_c_q[0] <= centre_x_i;
      held_c_q[1] <= centre_y_i;
      held_c_q[2] <= centre_z_i;
      held_e_q[0] <= extent_x_i;
      held_e_q[1] <= extent_y_i;
      held_e_q[2] <= extent_z_i;
    end
    if (accept_second) begin
      cur_kind_q <= kind_i;
      cur_c_q[0] <= centre_x_i;
      cur_c_q[1] <= centre_y_i;
      cur_c_q[2] <= centre_z_i;
      cur_e_q[0] <= extent_x_i;
      cur_e_q[1] <= extent_y_i;
      cur_e_q[2] <= extent_z_i;
    end
  end

  // distance, product and accumulator datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      d_q <= d_sel;
    end
    prod_q <= mul_p;
    psh_q  <= step_q;
    ptgt_q <= (axis_q == AX_RAD);
    if (accept_second) begin
      acc_q    <= '0;
      rsq_q    <= '0;
      boxhit_q <= 1'b1;
    end else begin
      if (padd_q) begin
        if (ptgt_q) begin
          rsq_q <= rsq_q + prod_sh;
        end else begin
          acc_q <= acc_q + prod_sh;
        end
      end
      if (state_q == ST_PREP && box_pair && adiff > esum) begin
        boxhit_q <= 1'b0;
      end
    end
    if (state_q == ST_CMP) begin
      hit_q <= box_pair ? boxhit_q : (acc_q <= rsq_q);
      pk_q  <= {held_kind_q, cur_kind_q};
    end
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign pair_kind_o = pk_q;

endmodule : shape_pair_overlap_test

`default_nettype wire

/* src/spot_check.sv */
// port-level checks for the shape pair overlap test, bound to the top level
`default_nettype none

module spot_check (
  input wire clk_i,
  input wire rst_ni,
  input wire start_i,
  input wire busy_o,
  input wire second_i,
  input wire done_o
);

  // a result beat always follows a busy stretch
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result beat without a preceding busy cycle");

  // a first beat is stored without going busy
  a_first_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !second_i) |=> !busy_o)
    else $error("first beat made the block busy");

  // a second beat starts the test
  a_second_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && second_i) |=> busy_o)
    else $error("second beat did not start the test");

  // a result beat is never repeated back to back
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beat repeated");

endmodule : spot_check

bind shape_pair_overlap_test spot_check u_spot_check (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .second_i (second_i),
  .done_o   (done_o)
);

`default_nettype wire
